FILE: rtl/core/crwa_pkg.sv
`default_nettype none
package crwa_pkg;

    // Window and counter geometry
    localparam int HISTORY_DEPTH = 64;
    localparam int NUM_CNT       = 6;
    localparam int DATA_W        = 64;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int MEM_DEPTH     = HISTORY_DEPTH * NUM_CNT;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int CTR_W         = $clog2(NUM_CNT);
    localparam int BIT_W         = $clog2(DATA_W);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);
    localparam logic [CTR_W-1:0]  LAST_CTR  = CTR_W'(NUM_CNT - 1);
    localparam logic [BIT_W-1:0]  LAST_BIT  = BIT_W'(DATA_W - 1);

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DELTA = 5'b00010,
        S_SUM   = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Slot to flat memory address
    function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [CTR_W-1:0] ctr);
        mem_addr = ADDR_W'(ADDR_W'(slot) * ADDR_W'(NUM_CNT)) + ADDR_W'(ctr);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/crwa_ram.sv
`default_nettype none
module crwa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/counter_rate_window_average.sv
`default_nettype none
// Sliding-window average and peak of six cumulative interface counters. Each input
// transaction is one counter snapshot; each produces one output transaction with the
// six window averages (sum of non-decreasing deltas over the window, saturated at
// 64 bits, floor-divided by the number of snapshots held) and the six all-time peak
// deltas. A single sequencer shares one adder and one bit-serial divider over the
// counters in turn; the window holds at most 64 snapshots. The window sum reads one
// history entry per cycle from a single memory and the divider retires one quotient
// bit per cycle. With fewer than two snapshots held the averages hold. The input side
// is not ready while an item is in work.
module counter_rate_window_average (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_rx_byte_total,
    input  wire logic [63:0] i_rx_packet_total,
    input  wire logic [63:0] i_rx_drop_total,
    input  wire logic [63:0] i_tx_byte_total,
    input  wire logic [63:0] i_tx_packet_total,
    input  wire logic [63:0] i_tx_drop_total,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_rx_byte_average,
    output logic [63:0]      o_rx_packet_average,
    output logic [63:0]      o_rx_drop_average,
    output logic [63:0]      o_tx_byte_average,
    output logic [63:0]      o_tx_packet_average,
    output logic [63:0]      o_tx_drop_average,
    output logic [63:0]      o_rx_byte_peak,
    output logic [63:0]      o_rx_packet_peak,
    output logic [63:0]      o_rx_drop_peak,
    output logic [63:0]      o_tx_byte_peak,
    output logic [63:0]      o_tx_packet_peak,
    output logic [63:0]      o_tx_drop_peak
);

    crwa_pkg::t_state r_state;

    logic [crwa_pkg::DATA_W-1:0] r_in   [crwa_pkg::NUM_CNT];
    logic [crwa_pkg::DATA_W-1:0] r_last [crwa_pkg::NUM_CNT];
    logic [crwa_pkg::DATA_W-1:0] r_peak [crwa_pkg::NUM_CNT];
    logic [crwa_pkg::DATA_W-1:0] r_avg  [crwa_pkg::NUM_CNT];

    logic [crwa_pkg::SLOT_W-1:0] r_slot;
    logic [crwa_pkg::SLOT_W-1:0] r_rslot;
    logic [crwa_pkg::CNT_W-1:0]  r_filled;
    logic [crwa_pkg::CNT_W-1:0]  r_n;
    logic [crwa_pkg::CNT_W-1:0]  r_k;
    logic [crwa_pkg::CTR_W-1:0]  r_ctr;
    logic [crwa_pkg::BIT_W-1:0]  r_bit;
    logic                        r_rd_vld;
    logic [crwa_pkg::DATA_W-1:0] r_acc;
    logic [crwa_pkg::DATA_W-1:0] r_quo;
    logic [crwa_pkg::CNT_W-1:0]  r_rem;
    logic                        r_out_valid;

    logic [crwa_pkg::DATA_W-1:0] w_cur;
    logic [crwa_pkg::DATA_W-1:0] w_prev;
    logic [crwa_pkg::DATA_W-1:0] w_delta;
    logic [crwa_pkg::DATA_W-1:0] w_contrib;
    logic                        w_we;
    logic [crwa_pkg::DATA_W-1:0] w_rdata;
    logic [crwa_pkg::DATA_W:0]   w_sum;
    logic [crwa_pkg::DATA_W-1:0] w_acc_next;
    logic [crwa_pkg::CNT_W:0]    w_trial;
    logic                        w_qbit;
    logic [crwa_pkg::CNT_W-1:0]  w_rem_next;
    logic [crwa_pkg::DATA_W-1:0] w_quo_next;
    logic [crwa_pkg::CNT_W-1:0]  w_filled_next;
    logic [crwa_pkg::SLOT_W-1:0] w_slot_next;
    logic                        w_sum_done;

    assign o_in_ready  = (r_state == crwa_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    // Delta path for the counter in work
    assign w_cur     = r_in[r_ctr];
    assign w_prev    = r_last[r_ctr];
    assign w_delta   = w_cur - w_prev;
    assign w_contrib = (w_cur >= w_prev) ? w_delta : '0;
    assign w_we      = (r_state == crwa_pkg::S_DELTA) && (r_filled != '0);

    // Saturating accumulate of one history entry
    assign w_sum      = {1'b0, r_acc} + {1'b0, w_rdata};
    assign w_acc_next = w_sum[crwa_pkg::DATA_W] ? '1 : w_sum[crwa_pkg::DATA_W-1:0];
    assign w_sum_done = (r_k == r_n) && !r_rd_vld;

    // One restoring division step
    assign w_trial    = {r_rem, r_quo[crwa_pkg::DATA_W-1]};
    assign w_qbit     = (w_trial >= {1'b0, r_filled});
    assign w_rem_next = w_qbit ? crwa_pkg::CNT_W'(w_trial - {1'b0, r_filled})
                               : crwa_pkg::CNT_W'(w_trial);
    assign w_quo_next = {r_quo[crwa_pkg::DATA_W-2:0], w_qbit};

    // Fill count and write slot after this snapshot
    assign w_filled_next = (r_filled == crwa_pkg::FULL_CNT) ? r_filled
                                                             : r_filled + 1'b1;
    assign w_slot_next   = (r_slot == crwa_pkg::LAST_SLOT) ? '0 : r_slot + 1'b1;

    crwa_ram #(
        .WIDTH(crwa_pkg::DATA_W),
        .DEPTH(crwa_pkg::MEM_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(crwa_pkg::mem_addr(r_slot, r_ctr)),
        .i_wdata(w_contrib),
        .i_raddr(crwa_pkg::mem_addr(r_rslot, r_ctr)),
        .o_rdata(w_rdata)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crwa_pkg::S_IDLE;
            r_slot      <= '0;
            r_filled    <= '0;
            r_ctr       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < crwa_pkg::NUM_CNT; i++) begin
                r_peak[i] <= '0;
                r_avg[i]  <= '0;
            end
            o_rx_byte_average   <= '0;
            o_rx_packet_average <= '0;
            o_rx_drop_average   <= '0;
            o_tx_byte_average   <= '0;
            o_tx_packet_average <= '0;
            o_tx_drop_average   <= '0;
            o_rx_byte_peak      <= '0;
            o_rx_packet_peak    <= '0;
            o_rx_drop_peak      <= '0;
            o_tx_byte_peak      <= '0;
            o_tx_packet_peak    <= '0;
            o_tx_drop_peak      <= '0;
        end else begin
            // drop the result once taken, unless a new one loads now
            if (r_out_valid && i_out_ready && (r_state != crwa_pkg::S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                crwa_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_in[0] <= i_rx_byte_total;
                        r_in[1] <= i_rx_packet_total;
                        r_in[2] <= i_rx_drop_total;
                        r_in[3] <= i_tx_byte_total;
                        r_in[4] <= i_tx_packet_total;
                        r_in[5] <= i_tx_drop_total;
                        r_ctr   <= '0;
                        r_state <= crwa_pkg::S_DELTA;
                    end
                end
                crwa_pkg::S_DELTA: begin
                    if ((r_filled != '0) && (r_peak[r_ctr] < w_delta)) begin
                        r_peak[r_ctr] <= w_delta;
                    end
                    r_last[r_ctr] <= w_cur;
                    if (r_ctr == crwa_pkg::LAST_CTR) begin
                        r_filled <= w_filled_next;
                        r_slot   <= w_slot_next;
                        r_ctr    <= '0;
                        r_rslot  <= r_slot;
                        r_n      <= w_filled_next - 1'b1;
                        r_k      <= '0;
                        r_acc    <= '0;
                        r_rd_vld <= 1'b0;
                        r_state  <= (w_filled_next >= crwa_pkg::CNT_W'(2))
                                    ? crwa_pkg::S_SUM : crwa_pkg::S_DONE;
                    end else begin
                        r_ctr <= r_ctr + 1'b1;
                    end
                end
                crwa_pkg::S_SUM: begin
                    // issue one read per cycle, accumulate the one before
                    if (r_rd_vld) begin
                        r_acc <= w_acc_next;
                    end
                    if (r_k != r_n) begin
                        r_k      <= r_k + 1'b1;
                        r_rslot  <= (r_rslot == '0) ? crwa_pkg::LAST_SLOT
                                                    : r_rslot - 1'b1;
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (w_sum_done) begin
                        r_quo   <= r_acc;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_state <= crwa_pkg::S_DIV;
                    end
                end
                crwa_pkg::S_DIV: begin
                    r_quo <= w_quo_next;
                    r_rem <= w_rem_next;
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == crwa_pkg::LAST_BIT) begin
                        r_avg[r_ctr] <= w_quo_next;
                        r_rslot      <= (r_slot == '0) ? crwa_pkg::LAST_SLOT
                                                       : r_slot - 1'b1;
                        r_k          <= '0;
                        r_acc        <= '0;
                        r_rd_vld     <= 1'b0;
                        if (r_ctr == crwa_pkg::LAST_CTR) begin
                            r_ctr   <= '0;
                            r_state <= crwa_pkg::S_DONE;
                        end else begin
                            r_ctr   <= r_ctr + 1'b1;
                            r_state <= crwa_pkg::S_SUM;
                        end
                    end
                end
                crwa_pkg::S_DONE: begin
                    // load the output register once it is free
                    if (!r_out_valid || i_out_ready) begin
                        o_rx_byte_average   <= r_avg[0];
                        o_rx_packet_average <= r_avg[1];
                        o_rx_drop_average   <= r_avg[2];
                        o_tx_byte_average   <= r_avg[3];
                        o_tx_packet_average <= r_avg[4];
                        o_tx_drop_average   <= r_avg[5];
                        o_rx_byte_peak      <= r_peak[0];
                        o_rx_packet_peak    <= r_peak[1];
                        o_rx_drop_peak      <= r_peak[2];
                        o_tx_byte_peak      <= r_peak[3];
                        o_tx_packet_peak    <= r_peak[4];
                        o_tx_drop_peak      <= r_peak[5];
                        r_out_valid         <= 1'b1;
                        r_state             <= crwa_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= crwa_pkg::S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/crwa_checker.sv
`default_nettype none
module crwa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_rx_byte_peak,
    input wire logic [63:0] o_tx_drop_peak
);

    // An accepted snapshot keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transaction");

    // Reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Peaks never fall when the result valid rises
    a_rx_peak_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_rx_byte_peak >= $past(o_rx_byte_peak)))
        else $error("rx byte peak decreased");

    a_tx_peak_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_tx_drop_peak >= $past(o_tx_drop_peak)))
        else $error("tx drop peak decreased");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_rx_byte_peak)))
        else $error("stalled result changed");

endmodule

bind counter_rate_window_average crwa_checker u_crwa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_rx_byte_peak(o_rx_byte_peak),
    .o_tx_drop_peak(o_tx_drop_peak)
);
`default_nettype wire
